/* rtl/rnd_pkg.sv */
// ----------------------------------------------------------------------------
// rnd_pkg
// Shared types, constants and the letter lookup for the roman numeral decoder.
// ----------------------------------------------------------------------------
package rnd_pkg;

    // width of the running sum, saturating at its top
    localparam int SUM_WIDTH = 16;
    localparam int VALUE_WIDTH = 16;
    localparam int LETTER_WIDTH = 10;

    // classified word queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // ascii codes of the seven letters
    localparam logic [7:0] CHAR_I = 8'h49;
    localparam logic [7:0] CHAR_V = 8'h56;
    localparam logic [7:0] CHAR_X = 8'h58;
    localparam logic [7:0] CHAR_L = 8'h4C;
    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_D = 8'h44;
    localparam logic [7:0] CHAR_M = 8'h4D;

    typedef struct packed {
        logic [7:0] symbol;
        logic       last;
    } in_word_t;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] value;
        logic                   bad_symbol;
    } out_word_t;

    // classified character as held in the queue
    typedef struct packed {
        logic [LETTER_WIDTH-1:0] letter_val;
        logic                    bad;
        logic                    last;
    } cls_word_t;

    // queue status seen by the back end
    typedef struct packed {
        logic      avail;
        cls_word_t head;
    } q_status_t;

    // letter value, zero for anything that is not a roman letter
    function automatic logic [LETTER_WIDTH-1:0] letter_value(input logic [7:0] c);
        logic [LETTER_WIDTH-1:0] v;
        case (c)
            CHAR_I:  v = LETTER_WIDTH'(1);
            CHAR_V:  v = LETTER_WIDTH'(5);
            CHAR_X:  v = LETTER_WIDTH'(10);
            CHAR_L:  v = LETTER_WIDTH'(50);
            CHAR_C:  v = LETTER_WIDTH'(100);
            CHAR_D:  v = LETTER_WIDTH'(500);
            CHAR_M:  v = LETTER_WIDTH'(1000);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/rnd_front.sv */
// ----------------------------------------------------------------------------
// rnd_front
// Accepts input words and classifies each character into its letter value.
// ----------------------------------------------------------------------------
module rnd_front
(
    input  logic               in_valid,
    output logic               in_stall,
    input  rnd_pkg::in_word_t  in_word,
    input  logic               q_full,
    output logic               push,
    output rnd_pkg::cls_word_t push_word
);

    // stall while the queue has no room
    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    // letter lookup and bad character flag
    always_comb
    begin
        push_word.letter_val = rnd_pkg::letter_value(in_word.symbol);
        push_word.bad        = (push_word.letter_val == '0);
        push_word.last       = in_word.last;
    end

endmodule

/* rtl/rnd_queue.sv */
// ----------------------------------------------------------------------------
// rnd_queue
// Short register queue of classified words between the front and back ends.
// ----------------------------------------------------------------------------
module rnd_queue
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  rnd_pkg::cls_word_t  push_word,
    input  logic                pop,
    output logic                full,
    output rnd_pkg::q_status_t  status
);

    rnd_pkg::cls_word_t                  slot_reg [rnd_pkg::QUEUE_DEPTH];
    logic [rnd_pkg::QUEUE_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [rnd_pkg::QUEUE_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [rnd_pkg::QUEUE_CNT_W-1:0]     count_reg, count_next;

    assign full          = (count_reg == rnd_pkg::QUEUE_CNT_W'(rnd_pkg::QUEUE_DEPTH));
    assign status.avail  = (count_reg != '0);
    assign status.head   = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + rnd_pkg::QUEUE_PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + rnd_pkg::QUEUE_PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + rnd_pkg::QUEUE_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - rnd_pkg::QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

/* rtl/rnd_back.sv */
// ----------------------------------------------------------------------------
// rnd_back
// Applies the pair rule to classified words and registers the decoded result.
// ----------------------------------------------------------------------------
module rnd_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  rnd_pkg::q_status_t  status,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output rnd_pkg::out_word_t  out_word
);

    localparam int SW = rnd_pkg::SUM_WIDTH;
    localparam int LW = rnd_pkg::LETTER_WIDTH;

    logic [SW-1:0]      total_reg, total_next;
    logic [LW-1:0]      pend_reg, pend_next;
    logic               err_reg, err_next;
    logic               out_valid_reg, out_valid_next;
    rnd_pkg::out_word_t out_word_reg, out_word_next;

    logic               out_free;
    logic [LW-1:0]      amount;
    logic [LW-1:0]      pend_step;
    logic               err_step;
    logic [SW:0]        sum1;
    logic [SW-1:0]      total1;
    logic [SW:0]        sum2;
    logic [SW-1:0]      total2;
    logic [32:0]        total2_wide;

    assign out_free  = !out_valid_reg || !out_stall;
    // a word that ends a numeral waits for room in the output register
    assign pop       = status.avail && (!status.head.last || out_free);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // pair rule with one pending value
    always_comb
    begin
        amount    = '0;
        pend_step = pend_reg;
        err_step  = err_reg;
        if (status.head.bad)
        begin
            err_step = 1'b1;
        end
        else if (pend_reg == '0)
        begin
            pend_step = status.head.letter_val;
        end
        else if (pend_reg < status.head.letter_val)
        begin
            amount    = status.head.letter_val - pend_reg;
            pend_step = '0;
        end
        else
        begin
            amount    = pend_reg;
            pend_step = status.head.letter_val;
        end
    end

    // saturating adds: the step, then the final flush of the pending value
    always_comb
    begin
        sum1        = {1'b0, total_reg} + (SW + 1)'(amount);
        total1      = sum1[SW] ? {SW{1'b1}} : sum1[SW-1:0];
        sum2        = {1'b0, total1} + (SW + 1)'(pend_step);
        total2      = sum2[SW] ? {SW{1'b1}} : sum2[SW-1:0];
        total2_wide = 33'(total2);
    end

    // state and output register update
    always_comb
    begin
        total_next     = total_reg;
        pend_next      = pend_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_word_next  = out_word_reg;
        if (pop)
        begin
            if (status.head.last)
            begin
                total_next     = '0;
                pend_next      = '0;
                err_next       = 1'b0;
                out_valid_next = 1'b1;
                out_word_next.value = (total2_wide > 33'(16'hFFFF)) ?
                    {rnd_pkg::VALUE_WIDTH{1'b1}} : rnd_pkg::VALUE_WIDTH'(total2_wide);
                out_word_next.bad_symbol = err_step;
            end
            else
            begin
                total_next = total1;
                pend_next  = pend_step;
                err_next   = err_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= '0;
            pend_reg      <= '0;
            err_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            total_reg     <= total_next;
            pend_reg      <= pend_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result word, no reset needed
    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

endmodule

/* rtl/roman_numeral_decoder_unit.sv */
// ----------------------------------------------------------------------------
// roman_numeral_decoder_unit
// Decodes a roman numeral, one ascii character per word, into an integer.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one character per word (symbol, last); last
//   marks the final character of a numeral. The output channel carries one
//   word per numeral: the value, saturated at 65535, and bad_symbol, set when
//   any character of the numeral was not one of I V X L C D M.
//   Both channels use valid and stall; a word moves when valid is high and
//   stall is low.
//   A character is classified on entry and written into a two-word queue;
//   the back end takes one word a cycle from the queue, so one character per
//   cycle is sustained while the output register has room. out_valid rises
//   once the final character has gone through the queue slot and then the
//   output register.
//   When the receiver stalls, the result holds in the output register; the
//   back end keeps absorbing characters of the next numeral and stops only
//   at that numeral's final character, after which the queue fills and
//   in_stall rises.
//   Reset clears the queue, the running sum, the pending value and the
//   error flag; the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
module roman_numeral_decoder_unit
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  rnd_pkg::in_word_t  in_word,
    output logic               out_valid,
    input  logic               out_stall,
    output rnd_pkg::out_word_t out_word
);

    logic               q_full;
    logic               push;
    logic               pop;
    rnd_pkg::cls_word_t push_word;
    rnd_pkg::q_status_t q_status;

    // classify incoming characters
    rnd_front u_front
    (
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .q_full    (q_full),
        .push      (push),
        .push_word (push_word)
    );

    // decouple front and back
    rnd_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .full      (q_full),
        .status    (q_status)
    );

    // accumulate and emit
    rnd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .status    (q_status),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word)
    );

endmodule
